### hw/rtl/tagged_ring_fifo_core_macros.svh
// ----------------------------------------------------------------------------
// tagged_ring_fifo_core_macros.svh
// Assertion shorthands shared by the tagged ring FIFO files.
// ----------------------------------------------------------------------------
`ifndef TAGGED_RING_FIFO_CORE_MACROS_SVH
`define TAGGED_RING_FIFO_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TRF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define TRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/trf_pkg.sv
// ----------------------------------------------------------------------------
// trf_pkg
// Types and constants of the tagged ring FIFO.
// ----------------------------------------------------------------------------
package trf_pkg;

   localparam int unsigned DEPTH_DEF  = 256;
   localparam int unsigned DATA_W     = 32;
   localparam int unsigned CNT_W      = 9;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 9;

   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(256);

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERWRITE = 1'b1;

   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_PEEK   = 3'd2,
      OP_POP_V  = 3'd3,
      OP_QUERY  = 3'd4,
      OP_UNHIDE = 3'd5,
      OP_CLEAR  = 3'd6
   } trf_op_type;

   typedef struct packed {
      trf_op_type        operation;
      logic [DATA_W-1:0] push_data;
      logic              hide;
   } trf_req_type;

   typedef struct packed {
      logic              ok;
      logic [DATA_W-1:0] read_data;
      logic [CNT_W-1:0]  entry_count;
   } trf_rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0] capacity;
      logic             overwrite_oldest;
   } trf_cfg_type;

   // one memory row: marks and word together
   typedef struct packed {
      logic              hidden;
      logic              visited;
      logic [DATA_W-1:0] word;
   } trf_entry_type;

endpackage

### hw/rtl/trf_ram.sv
// ----------------------------------------------------------------------------
// trf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module trf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/trf_engine.sv
// ----------------------------------------------------------------------------
// trf_engine
// Pointer/count state and read-modify-write sequencer around the entry RAM.
// ----------------------------------------------------------------------------
module trf_engine import trf_pkg::*; #(
   parameter int unsigned DEPTH = DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  trf_cfg_type                   cfg,
   input  logic                          start,
   input  trf_req_type                   req,
   output logic                          busy,
   output logic                          rsp_valid,
   output trf_rsp_type                   rsp,
   output logic                          mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]      mem_rd_addr,
   input  trf_entry_type                 mem_rd_data,
   output logic                          mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]      mem_wr_addr,
   output trf_entry_type                 mem_wr_data
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned LW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_FILL = 3'b100
   } trf_state_type;

   trf_state_type    state_ff, state_in;
   trf_req_type      req_ff, req_in;
   logic [AW-1:0]    wr_pos_ff, wr_pos_in;
   logic [AW-1:0]    rd_pos_ff, rd_pos_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   trf_rsp_type      rsp_ff, rsp_in;

   logic [LW-1:0]     cap_use;
   logic [AW-1:0]     wr_pos_adv, rd_pos_adv;
   logic              nonempty, room;
   logic              emit;
   logic              ok_c;
   logic [DATA_W-1:0] read_c;

   // capacity clamped to 1..DEPTH
   always_comb begin
      cap_use = LW'(cfg.capacity);
      if (cap_use == '0) begin
         cap_use = LW'(1);
      end else if (cap_use > LW'(DEPTH)) begin
         cap_use = LW'(DEPTH);
      end
   end

   function automatic logic [AW-1:0] advance(input logic [AW-1:0] pos,
                                             input logic [LW-1:0] cap);
      logic [LW-1:0] nxt;
      nxt = LW'(pos) + LW'(1);
      return (nxt >= cap) ? '0 : nxt[AW-1:0];
   endfunction

   assign wr_pos_adv = advance(wr_pos_ff, cap_use);
   assign rd_pos_adv = advance(rd_pos_ff, cap_use);
   assign nonempty   = (count_ff != '0);
   assign room       = (LW'(count_ff) < cap_use);

   // head entry is read at the accept edge; valid throughout ST_EXEC
   assign mem_rd_en   = (state_ff == ST_IDLE) && start;
   assign mem_rd_addr = rd_pos_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      wr_pos_in    = wr_pos_ff;
      rd_pos_in    = rd_pos_ff;
      count_in     = count_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = rd_pos_ff;
      mem_wr_data  = mem_rd_data;
      emit         = 1'b0;
      ok_c         = 1'b0;
      read_c       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            emit     = 1'b1;
            unique case (req_ff.operation)
               OP_PUSH: begin
                  if (!room && cfg.overwrite_oldest && nonempty) begin
                     // drop the oldest now, write the new word next cycle
                     mem_wr_en           = 1'b1;
                     mem_wr_data.hidden  = 1'b0;
                     mem_wr_data.visited = 1'b0;
                     rd_pos_in           = rd_pos_adv;
                     count_in            = count_ff - CNT_W'(1);
                     state_in            = ST_FILL;
                     emit                = 1'b0;
                  end else if (room) begin
                     mem_wr_en           = 1'b1;
                     mem_wr_addr         = wr_pos_ff;
                     mem_wr_data.hidden  = req_ff.hide;
                     mem_wr_data.visited = 1'b0;
                     mem_wr_data.word    = req_ff.push_data;
                     wr_pos_in           = wr_pos_adv;
                     count_in            = count_ff + CNT_W'(1);
                     ok_c                = 1'b1;
                  end
               end
               OP_POP: begin
                  if (nonempty && !mem_rd_data.hidden) begin
                     read_c              = mem_rd_data.word;
                     mem_wr_en           = 1'b1;
                     mem_wr_data.visited = 1'b0;
                     rd_pos_in           = rd_pos_adv;
                     count_in            = count_ff - CNT_W'(1);
                     ok_c                = 1'b1;
                  end
               end
               OP_PEEK: begin
                  if (nonempty && !mem_rd_data.hidden) begin
                     read_c              = mem_rd_data.word;
                     mem_wr_en           = 1'b1;
                     mem_wr_data.visited = 1'b1;
                     ok_c                = 1'b1;
                  end
               end
               OP_POP_V: begin
                  if (nonempty && mem_rd_data.visited) begin
                     mem_wr_en           = 1'b1;
                     mem_wr_data.visited = 1'b0;
                     rd_pos_in           = rd_pos_adv;
                     count_in            = count_ff - CNT_W'(1);
                     ok_c                = 1'b1;
                  end
               end
               OP_QUERY: begin
                  ok_c = nonempty && mem_rd_data.visited;
               end
               OP_UNHIDE: begin
                  if (nonempty && mem_rd_data.hidden) begin
                     mem_wr_en          = 1'b1;
                     mem_wr_data.hidden = 1'b0;
                     ok_c               = 1'b1;
                  end
               end
               OP_CLEAR: begin
                  wr_pos_in = '0;
                  rd_pos_in = '0;
                  count_in  = '0;
                  ok_c      = 1'b1;
               end
               default: begin
                  ok_c = 1'b0;
               end
            endcase
         end
         ST_FILL: begin
            state_in            = ST_IDLE;
            emit                = 1'b1;
            mem_wr_en           = 1'b1;
            mem_wr_addr         = wr_pos_ff;
            mem_wr_data.hidden  = req_ff.hide;
            mem_wr_data.visited = 1'b0;
            mem_wr_data.word    = req_ff.push_data;
            wr_pos_in           = wr_pos_adv;
            count_in            = count_ff + CNT_W'(1);
            ok_c                = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = emit;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_in.ok          = ok_c;
         rsp_in.read_data   = read_c;
         rsp_in.entry_count = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_pos_ff    <= '0;
         rd_pos_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_pos_ff    <= wr_pos_in;
         rd_pos_ff    <= rd_pos_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

### hw/rtl/tagged_ring_fifo_core.sv
// ----------------------------------------------------------------------------
// tagged_ring_fifo_core
// Ring FIFO of words with per-entry hidden and visited marks.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive req_data and raise start; the beat is taken on a
//   rising edge with start high and busy low. Operations are push, pop, peek,
//   pop-if-visited, query-visited, unhide and clear.
//   Result channel: every command gives one result beat on rsp_data, flagged
//   by rsp_valid for a single cycle. The receiver cannot stall it, so it
//   must capture the beat in that cycle.
//   Timing: rsp_valid is registered and rises out of the ST_EXEC state (out
//   of ST_FILL for a push that overwrites the oldest entry). busy is high
//   through ST_EXEC and ST_FILL, so a new command is taken only once the
//   last one is done; the result beat of one command overlaps the accept of
//   the next. The pacing is set by the registered read of the entry RAM
//   followed by its write-back, and by the single RAM write port when a push
//   has to retire the oldest entry first.
//   CSR channel: csr_ready is always high; write capacity (index 0) and
//   overwrite_oldest (index 1) only while no command is in flight.
//   Reset: pointers and count go to zero, capacity to 256, overwrite off.
//   RAM contents are not cleared; the head slot is read at every accept, even one never written.
// ----------------------------------------------------------------------------
`include "tagged_ring_fifo_core_macros.svh"

module tagged_ring_fifo_core import trf_pkg::*; #(
   parameter int unsigned DEPTH = DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  trf_req_type           req_data,
   output logic                  rsp_valid,
   output trf_rsp_type           rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned AW = $clog2(DEPTH);

   trf_cfg_type   cfg_ff, cfg_in;
   logic          mem_rd_en, mem_wr_en;
   logic [AW-1:0] mem_rd_addr, mem_wr_addr;
   trf_entry_type mem_rd_data, mem_wr_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CAPACITY:  cfg_in.capacity         = CNT_W'(csr_wdata);
            CSR_OVERWRITE: cfg_in.overwrite_oldest = csr_wdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.capacity         <= CAP_RESET;
         cfg_ff.overwrite_oldest <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   trf_engine #(
      .DEPTH (DEPTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .start       (start),
      .req         (req_data),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   trf_ram #(
      .WIDTH ($bits(trf_entry_type)),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // a taken command keeps the engine busy for at least the next cycle
   `TRF_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept without busy")

   // a result beat only follows a cycle of work
   `TRF_ASSERT_IMPLY(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy), "result without work")

   // one beat per command: never two result beats back to back
   `TRF_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result beat repeated")

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for tagged_ring_fifo_core. A table of hand-picked
// commands covers the empty, hidden, visited, clear, full and overwrite cases
// and out-of-range capacities, most with typed results. Random phases at
// several capacities and sender gap rates follow, checked by a FIFO mirror.
// ----------------------------------------------------------------------------
module testbench import trf_pkg::*;;

   localparam int unsigned RING_DEPTH = DEPTH_DEF;
   localparam int          MAX_GAP    = 16;
   localparam trf_op_type  OP_UNUSED  = trf_op_type'(3'd7);

   typedef enum bit {ROW_CMD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] val;
      trf_req_type           cmd;
      bit                    typed;
      trf_rsp_type           want;
   } table_row_type;

   typedef struct {
      int unsigned cap;
      bit          ovw;
      int          items;
      int          push_pct;
      int          gap_pct;
      bit          hold;
   } phase_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   trf_req_type           req_data  = '0;
   logic                  rsp_valid;
   trf_rsp_type           rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // mirror of the FIFO
   logic [DATA_W-1:0] mirror_word    [RING_DEPTH];
   logic              mirror_hidden  [RING_DEPTH];
   logic              mirror_visited [RING_DEPTH];
   int unsigned       mirror_wr;
   int unsigned       mirror_rd;
   int unsigned       mirror_held;
   logic [CNT_W-1:0]  mirror_cap;
   logic              mirror_ovw;

   trf_rsp_type   pending_results [$];
   table_row_type directed_rows [$];

   int err_count;
   int accepted_count;
   int checked_count;
   int csr_count;
   int refused_count;
   int overwrite_count;

   tagged_ring_fifo_core uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      err_count++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   // ---------------------------------------------------------------- mirror
   function automatic int unsigned cap_in_effect();
      if (mirror_cap == 0) return 1;
      if (mirror_cap > RING_DEPTH) return RING_DEPTH;
      return 32'(mirror_cap);
   endfunction

   function automatic int unsigned next_pos(input int unsigned p);
      int unsigned n;
      n = p + 1;
      if (n >= cap_in_effect() || n >= RING_DEPTH) n = 0;
      return n;
   endfunction

   function automatic void retire_oldest();
      mirror_visited[mirror_rd] = 1'b0;
      mirror_rd = next_pos(mirror_rd);
      mirror_held--;
   endfunction

   function automatic trf_rsp_type predict_fifo_result(input trf_req_type r);
      trf_rsp_type res;
      int unsigned oldest;
      logic        room;
      logic        nonempty;
      res      = '0;
      oldest   = mirror_rd;
      nonempty = (mirror_held != 0);
      case (r.operation)
         OP_PUSH: begin
            room = (mirror_held < cap_in_effect());
            // overwrite: oldest is unhidden and thrown away first
            if (!room && mirror_ovw && nonempty) begin
               mirror_hidden[oldest] = 1'b0;
               retire_oldest();
               room = 1'b1;
               overwrite_count++;
            end
            if (room) begin
               mirror_word[mirror_wr]    = r.push_data;
               mirror_hidden[mirror_wr]  = r.hide;
               mirror_visited[mirror_wr] = 1'b0;
               mirror_wr = next_pos(mirror_wr);
               mirror_held++;
               res.ok = 1'b1;
            end else begin
               refused_count++;
            end
         end
         OP_POP: begin
            if (nonempty && !mirror_hidden[oldest]) begin
               res.read_data = mirror_word[oldest];
               retire_oldest();
               res.ok = 1'b1;
            end
         end
         OP_PEEK: begin
            if (nonempty && !mirror_hidden[oldest]) begin
               res.read_data = mirror_word[oldest];
               mirror_visited[oldest] = 1'b1;
               res.ok = 1'b1;
            end
         end
         OP_POP_V: begin
            if (nonempty && mirror_visited[oldest]) begin
               retire_oldest();
               res.ok = 1'b1;
            end
         end
         OP_QUERY: begin
            if (nonempty) res.ok = mirror_visited[oldest];
         end
         OP_UNHIDE: begin
            if (nonempty && mirror_hidden[oldest]) begin
               mirror_hidden[oldest] = 1'b0;
               res.ok = 1'b1;
            end
         end
         OP_CLEAR: begin
            mirror_wr   = 0;
            mirror_rd   = 0;
            mirror_held = 0;
            res.ok      = 1'b1;
         end
         default: begin
         end
      endcase
      res.entry_count = CNT_W'(mirror_held);
      return res;
   endfunction

   // ---------------------------------------------------------------- driving
   task automatic send_command(input trf_req_type r, input bit use_typed,
                               input trf_rsp_type typed, input int gap_pct);
      trf_rsp_type                   predicted;
      logic [$bits(trf_req_type)-1:0] junk;
      int                            gap;
      start    = 1'b1;
      req_data = r;
      do @(posedge clock); while (busy);
      predicted = predict_fifo_result(r);
      pending_results.push_back(use_typed ? typed : predicted);
      accepted_count++;
      @(negedge clock);
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < gap_pct) begin
         junk     = $bits(trf_req_type)'({$urandom(), $urandom()});
         start    = 1'b0;
         req_data = trf_req_type'(junk);
         gap++;
         @(negedge clock);
      end
   endtask

   // returns at a falling edge with nothing in flight
   task automatic wait_for_drain();
      start = 1'b0;
      while (pending_results.size() != 0 || busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      wait_for_drain();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_CAPACITY) mirror_cap = val;
      else mirror_ovw = val[0];
      csr_count++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic add_cmd(input trf_op_type op, input logic [DATA_W-1:0] data,
                          input logic hide, input bit typed, input logic ok,
                          input logic [DATA_W-1:0] rd, input int cnt);
      table_row_type row;
      row       = '{ROW_CMD, '0, '0, '0, typed, '0};
      row.cmd   = '{op, data, hide};
      row.want  = '{ok, rd, CNT_W'(cnt)};
      directed_rows.push_back(row);
   endtask

   task automatic add_csr(input logic [CSR_IDX_W-1:0] idx,
                          input logic [CSR_DATA_W-1:0] val);
      table_row_type row;
      row = '{ROW_CSR, idx, val, '0, 1'b0, '0};
      directed_rows.push_back(row);
   endtask

   // ---------------------------------------------------------------- checking
   always @(posedge clock) begin
      trf_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result beat with no command outstanding");
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            if (rsp_data.ok !== want.ok)
               report_mismatch($sformatf("beat %0d ok got %b want %b",
                  checked_count, rsp_data.ok, want.ok));
            if (rsp_data.read_data !== want.read_data)
               report_mismatch($sformatf("beat %0d read_data got %h want %h",
                  checked_count, rsp_data.read_data, want.read_data));
            if (rsp_data.entry_count !== want.entry_count)
               report_mismatch($sformatf("beat %0d entry_count got %0d want %0d",
                  checked_count, rsp_data.entry_count, want.entry_count));
         end
      end
   end

   initial begin
      #3_000_000;
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("tagged_ring_fifo_core regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus
   initial begin
      phase_type   phases [8];
      trf_req_type cmd;
      trf_op_type  op;
      int          roll;
      int          k;
      int          guard;

      mirror_wr   = 0;
      mirror_rd   = 0;
      mirror_held = 0;
      mirror_cap  = CAP_RESET;
      mirror_ovw  = 1'b0;

      // empty FIFO: every read-type command fails
      add_cmd(OP_POP,    32'h0, 1'b0, 1, 1'b0, 32'h0, 0);
      add_cmd(OP_PEEK,   32'h0, 1'b0, 1, 1'b0, 32'h0, 0);
      add_cmd(OP_POP_V,  32'h0, 1'b0, 1, 1'b0, 32'h0, 0);
      add_cmd(OP_QUERY,  32'h0, 1'b0, 1, 1'b0, 32'h0, 0);
      add_cmd(OP_UNHIDE, 32'h0, 1'b0, 1, 1'b0, 32'h0, 0);
      add_cmd(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 1, 1'b0, 32'h0, 0);
      // visited and hidden marks
      add_cmd(OP_PUSH,   32'hFFFF_FFFF, 1'b0, 1, 1'b1, 32'h0, 1);
      add_cmd(OP_PUSH,   32'h0000_0000, 1'b1, 1, 1'b1, 32'h0, 2);
      add_cmd(OP_POP_V,  32'h0, 1'b0, 1, 1'b0, 32'h0, 2);
      add_cmd(OP_PEEK,   32'h0, 1'b0, 1, 1'b1, 32'hFFFF_FFFF, 2);
      add_cmd(OP_QUERY,  32'h0, 1'b0, 1, 1'b1, 32'h0, 2);
      add_cmd(OP_POP_V,  32'h0, 1'b0, 1, 1'b1, 32'h0, 1);
      add_cmd(OP_POP,    32'h0, 1'b0, 1, 1'b0, 32'h0, 1);
      add_cmd(OP_UNHIDE, 32'h0, 1'b0, 1, 1'b1, 32'h0, 1);
      add_cmd(OP_POP,    32'h0, 1'b0, 1, 1'b1, 32'h0, 0);
      add_cmd(OP_CLEAR,  32'h0, 1'b0, 1, 1'b1, 32'h0, 0);
      // capacity of zero behaves as one; full refusal, then overwrite
      add_csr(CSR_CAPACITY, 9'd0);
      add_cmd(OP_PUSH,   32'h1234_5678, 1'b1, 1, 1'b1, 32'h0, 1);
      add_cmd(OP_PUSH,   32'h9ABC_DEF0, 1'b0, 1, 1'b0, 32'h0, 1);
      add_csr(CSR_OVERWRITE, 9'd1);
      add_cmd(OP_PUSH,   32'h9ABC_DEF0, 1'b0, 1, 1'b1, 32'h0, 1);
      add_cmd(OP_POP,    32'h0, 1'b0, 1, 1'b1, 32'h9ABC_DEF0, 0);
      // capacity above the store, then shrunk below the fill level
      add_csr(CSR_CAPACITY, 9'd511);
      add_csr(CSR_OVERWRITE, 9'd0);
      add_cmd(OP_PUSH,   32'h8000_0001, 1'b0, 1, 1'b1, 32'h0, 1);
      add_cmd(OP_PUSH,   32'h7FFF_FFFE, 1'b0, 1, 1'b1, 32'h0, 2);
      add_csr(CSR_CAPACITY, 9'd1);
      add_cmd(OP_PUSH,   32'h0000_0001, 1'b0, 1, 1'b0, 32'h0, 2);
      add_cmd(OP_POP,    32'h0, 1'b0, 0, 1'b0, 32'h0, 0);
      add_cmd(OP_POP,    32'h0, 1'b0, 0, 1'b0, 32'h0, 0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[n]) begin
         if (directed_rows[n].kind == ROW_CSR)
            write_register(directed_rows[n].idx, directed_rows[n].val);
         else
            send_command(directed_rows[n].cmd, directed_rows[n].typed,
                         directed_rows[n].want, 0);
      end

      // write every slot once so later stale reads are well defined
      write_register(CSR_CAPACITY, 9'd256);
      write_register(CSR_OVERWRITE, {8'($urandom()), 1'b0});
      cmd = '{OP_CLEAR, $urandom(), 1'b0};
      send_command(cmd, 0, '0, 0);
      for (int i = 0; i <= RING_DEPTH; i++) begin
         cmd = '{OP_PUSH, $urandom(), 1'($urandom_range(1))};
         send_command(cmd, 0, '0, 13);
      end

      phases[0] = '{511, 1'b1, 250, 70, 58, 1'b0};
      phases[1] = '{1, 1'b1, 120, 30, 0, 1'b0};
      phases[2] = '{2, 1'b1, 150, 55, 58, 1'b0};
      phases[3] = '{3, 1'b0, 150, 50, 13, 1'b0};
      phases[4] = '{$urandom_range(20, 4), 1'b1, 200, 50, 0, 1'b1};
      phases[5] = '{0, 1'($urandom_range(1)), 100, 50, 13, 1'b0};
      phases[6] = '{255, 1'b0, 200, 60, 0, 1'b0};
      phases[7] = '{256, 1'b0, 100, 40, 58, 1'b0};

      foreach (phases[p]) begin
         write_register(CSR_CAPACITY, CSR_DATA_W'(phases[p].cap));
         write_register(CSR_OVERWRITE, {8'($urandom()), phases[p].ovw});
         for (int i = 0; i < phases[p].items; i++) begin
            if (phases[p].hold && i == phases[p].items / 2) wait_for_drain();
            roll = $urandom_range(99);
            if (roll < phases[p].push_pct) begin
               op = OP_PUSH;
            end else begin
               k = $urandom_range(39);
               if (k < 12)      op = OP_POP;
               else if (k < 19) op = OP_PEEK;
               else if (k < 25) op = OP_POP_V;
               else if (k < 30) op = OP_QUERY;
               else if (k < 37) op = OP_UNHIDE;
               else if (k < 38) op = OP_CLEAR;
               else             op = OP_UNUSED;
            end
            cmd = '{op, $urandom(), ($urandom_range(99) < 20)};
            send_command(cmd, 0, '0, phases[p].gap_pct);
         end
      end

      start = 1'b0;
      guard = 0;
      while (pending_results.size() != 0 && guard < 1000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived",
            pending_results.size()));

      $display("ran %0d commands and %0d register writes, checked %0d result beats",
               accepted_count, csr_count, checked_count);
      $display("pushes refused on full: %0d, oldest entries overwritten: %0d",
               refused_count, overwrite_count);
      if (err_count == 0)
         $display("tagged_ring_fifo_core regression: pass");
      else
         $display("tagged_ring_fifo_core regression: fail");
      $finish;
   end

endmodule
